// ----- hdl/trapezoid_velocity_profile_defines.svh -----
// Assertion macros for the trapezoid velocity profile block.
`ifndef TRAPEZOID_VELOCITY_PROFILE_DEFINES_SVH
`define TRAPEZOID_VELOCITY_PROFILE_DEFINES_SVH
`ifndef SYNTH
`define TVP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TVP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TVP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TVP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hdl/tvp_pkg.sv -----
// Package: types, phase codes and fixed-point constants for the profile block.
`default_nettype none
package tvp_pkg;
  localparam int FRAC_BITS = 16;

  // configuration register indexes
  localparam logic [0:0] REG_MAX_VEL = 1'b0;
  localparam logic [0:0] REG_ACCEL   = 1'b1;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_START  = 2'd1,
    CMD_URGENT = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_ACCEL    = 3'd1,
    PH_CRUISE   = 3'd2,
    PH_BRAKE    = 3'd3,
    PH_UORDER   = 3'd4,
    PH_UBRAKE   = 3'd5,
    PH_FINISHED = 3'd6
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECIDE, ST_SQ, ST_DIV_BD, ST_WAIT_BD, ST_CHECK, ST_DIV_WA,
    ST_WAIT_WA, ST_STEP, ST_RAMP_MUL, ST_RAMP_SUB, ST_OUT
  } st_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic signed [31:0] remaining;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] velocity_out;
    logic signed [31:0] braking_distance;
    logic [2:0]  phase_out;
    logic        done_res;
  } out_word_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_LATCH_IN, OP_START, OP_URGENT, OP_TICK, OP_SQ, OP_DIV_BD,
    OP_SAVE_BD, OP_DIV_WA, OP_STEP, OP_RAMP_MUL, OP_RAMP_SUB, OP_LOAD_OUT
  } op_t;

  // command from controller to datapath
  typedef struct packed {
    op_t op;
  } ctl_t;

  // status from datapath to controller
  typedef struct packed {
    logic [1:0] cmd;
    phase_t     phase;
    logic       div_busy;
    logic       rem_gt_bd;
  } sts_t;

  localparam logic signed [31:0] SMAX = 32'sh7fffffff;
  localparam logic signed [31:0] SMIN = 32'sh80000000;

  function automatic logic signed [31:0] sat64(input logic signed [63:0] x);
    logic signed [31:0] r;
    r = x[31:0];
    if (x > 64'(SMAX)) r = SMAX;
    else if (x < 64'(SMIN)) r = SMIN;
    return r;
  endfunction
endpackage
`default_nettype wire

// ----- hdl/tvp_div.sv -----
// Iterative signed divider: 64-bit numerator by 33-bit denominator, saturated.
`default_nettype none
module tvp_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [63:0] num,
  input  wire logic signed [32:0] den,
  output logic                    busy,
  output logic signed [31:0]      quo
);
  logic [63:0] q_r, q_nxt;
  logic [33:0] rm_r, rm_nxt;
  logic [32:0] d_r, d_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt, zero_r, zero_nxt;
  logic        busy_r, busy_nxt;
  logic [33:0] sh;
  logic [63:0] mag;
  logic signed [64:0] sres;

  assign sh = {rm_r[32:0], q_r[63]};

  always_comb begin
    q_nxt = q_r; rm_nxt = rm_r; d_nxt = d_r; cnt_nxt = cnt_r;
    neg_nxt = neg_r; zero_nxt = zero_r; busy_nxt = busy_r;
    if (start) begin
      q_nxt = num[63] ? 64'(-num) : 64'(num);
      d_nxt = den[32] ? 33'(-den) : 33'(den);
      rm_nxt = '0;
      neg_nxt = num[63] ^ den[32];
      zero_nxt = (den == '0);
      cnt_nxt = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, d_r}) begin
        rm_nxt = sh - {1'b0, d_r};
        q_nxt = {q_r[62:0], 1'b1};
      end else begin
        rm_nxt = sh;
        q_nxt = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rm_r <= rm_nxt; d_r <= d_nxt;
    neg_r <= neg_nxt; zero_r <= zero_nxt;
  end

  assign mag = q_r;
  assign sres = neg_r ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  assign busy = busy_r;
  assign quo = zero_r ? tvp_pkg::SMAX :
               ((sres > 65'sh7fffffff) ? tvp_pkg::SMAX :
               ((sres < -65'sh80000000) ? tvp_pkg::SMIN : sres[31:0]));
endmodule
`default_nettype wire

// ----- hdl/tvp_datapath.sv -----
// Datapath: profile state registers, shared multiplier and divider.
`default_nettype none
`include "trapezoid_velocity_profile_defines.svh"
module tvp_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tvp_pkg::ctl_t     ctl,
  output tvp_pkg::sts_t          sts,
  input  wire tvp_pkg::in_word_t in_word,
  input  wire logic              cfg_we,
  input  wire logic [0:0]        cfg_idx,
  input  wire logic [31:0]       cfg_data,
  output tvp_pkg::out_word_t     out_word
);
  tvp_pkg::phase_t ph_r, ph_nxt;
  logic [31:0] cnt_r, cnt_nxt, bss_r, bss_nxt;
  logic signed [31:0] wa_r, wa_nxt, ref_r, ref_nxt, tv_r, tv_nxt;
  logic signed [31:0] vmax_r, acc_r;
  logic [1:0] cmd_r;
  logic signed [31:0] rem_r, bd_r, bd_nxt;
  logic done_r, done_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  tvp_pkg::out_word_t ow_r;
  logic [31:0] k;
  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  logic signed [31:0] sq_sat;
  logic div_go, div_busy;
  logic signed [63:0] div_num;
  logic signed [32:0] div_den;
  logic signed [31:0] quo;

  assign k = cnt_r - bss_r;

  // shared multiplier: square by default, accel times a sample count otherwise
  always_comb begin
    ma = 33'(tv_r);
    mb = 33'(tv_r);
    case (ctl.op)
      tvp_pkg::OP_STEP: begin
        ma = 33'(wa_r);
        mb = {1'b0, cnt_r};
      end
      tvp_pkg::OP_RAMP_MUL: begin
        ma = 33'(wa_r);
        mb = {1'b0, k};
      end
      default: ;
    endcase
  end
  assign mp = ma * mb;

  // prod_r holds the raw square from OP_SQ until the ramp multiply
  assign sq_sat = tvp_pkg::sat64(prod_r >>> tvp_pkg::FRAC_BITS);

  assign div_go = (ctl.op == tvp_pkg::OP_DIV_BD) || (ctl.op == tvp_pkg::OP_DIV_WA);
  assign div_num = 64'(sq_sat) <<< tvp_pkg::FRAC_BITS;
  assign div_den = (ctl.op == tvp_pkg::OP_DIV_BD) ? $signed({wa_r, 1'b0}) :
                                                    $signed({rem_r, 1'b0});

  tvp_div u_div (.clk(clk), .rst_n(rst_n), .start(div_go), .num(div_num),
    .den(div_den), .busy(div_busy), .quo(quo));

  always_comb begin
    ph_nxt = ph_r; cnt_nxt = cnt_r; bss_nxt = bss_r; wa_nxt = wa_r;
    ref_nxt = ref_r; tv_nxt = tv_r; bd_nxt = bd_r;
    done_nxt = done_r; prod_nxt = prod_r;
    case (ctl.op)
      tvp_pkg::OP_LATCH_IN: begin
        bd_nxt = '0; done_nxt = 1'b0;
      end
      tvp_pkg::OP_START: begin
        wa_nxt = acc_r; cnt_nxt = '0; bss_nxt = '0; ref_nxt = '0; tv_nxt = '0;
        ph_nxt = tvp_pkg::PH_ACCEL;
      end
      tvp_pkg::OP_URGENT: begin
        if (ph_r inside {tvp_pkg::PH_ACCEL, tvp_pkg::PH_CRUISE, tvp_pkg::PH_BRAKE})
          ph_nxt = tvp_pkg::PH_UORDER;
      end
      tvp_pkg::OP_TICK: begin
        cnt_nxt = cnt_r + 32'd1;
        case (ph_r)
          tvp_pkg::PH_UORDER: begin
            bss_nxt = cnt_r; ref_nxt = tv_r; ph_nxt = tvp_pkg::PH_UBRAKE;
          end
          tvp_pkg::PH_FINISHED: begin
            tv_nxt = '0; ph_nxt = tvp_pkg::PH_IDLE;
          end
          default: ;
        endcase
      end
      tvp_pkg::OP_SQ: prod_nxt = mp[63:0];
      tvp_pkg::OP_SAVE_BD: bd_nxt = quo;
      tvp_pkg::OP_STEP: begin
        // the count is already advanced; quo holds the re-fitted accel if any
        case (ph_r)
          tvp_pkg::PH_ACCEL: begin
            if (rem_r > bd_r) begin
              if (tv_r < vmax_r) tv_nxt = tvp_pkg::sat64(mp[63:0]);
              else ph_nxt = tvp_pkg::PH_CRUISE;
            end else begin
              bss_nxt = cnt_r - 32'd1; ref_nxt = tv_r; ph_nxt = tvp_pkg::PH_BRAKE;
            end
          end
          tvp_pkg::PH_CRUISE: begin
            if (rem_r > bd_r) tv_nxt = vmax_r;
            else begin
              bss_nxt = cnt_r - 32'd1; ref_nxt = tv_r; ph_nxt = tvp_pkg::PH_BRAKE;
            end
          end
          tvp_pkg::PH_BRAKE: begin
            if (rem_r > bd_r) begin
              wa_nxt = quo; ref_nxt = tv_r; bss_nxt = cnt_r - 32'd1;
            end
          end
          default: ;
        endcase
      end
      tvp_pkg::OP_RAMP_MUL: prod_nxt = mp[63:0];
      tvp_pkg::OP_RAMP_SUB: begin
        tv_nxt = tvp_pkg::sat64(64'(ref_r) - 64'(tvp_pkg::sat64(prod_r)));
        if (rem_r <= 32'sd0) begin
          tv_nxt = '0; ph_nxt = tvp_pkg::PH_FINISHED; done_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= tvp_pkg::PH_IDLE;
      cnt_r <= '0; bss_r <= '0; wa_r <= '0; ref_r <= '0; tv_r <= '0;
      vmax_r <= '0; acc_r <= '0;
    end else begin
      ph_r <= ph_nxt; cnt_r <= cnt_nxt; bss_r <= bss_nxt; wa_r <= wa_nxt;
      ref_r <= ref_nxt; tv_r <= tv_nxt;
      if (cfg_we && cfg_idx == tvp_pkg::REG_MAX_VEL) vmax_r <= cfg_data;
      if (cfg_we && cfg_idx == tvp_pkg::REG_ACCEL) acc_r <= cfg_data;
    end
    prod_r <= prod_nxt; bd_r <= bd_nxt; done_r <= done_nxt;
    if (ctl.op == tvp_pkg::OP_LATCH_IN) begin
      cmd_r <= in_word.cmd; rem_r <= in_word.remaining;
    end
    if (ctl.op == tvp_pkg::OP_LOAD_OUT) begin
      ow_r.velocity_out <= tv_r; ow_r.braking_distance <= bd_r;
      ow_r.phase_out <= ph_r; ow_r.done_res <= done_r;
    end
  end

  always_comb begin
    sts.cmd = cmd_r;
    sts.phase = ph_r;
    sts.div_busy = div_busy;
    sts.rem_gt_bd = rem_r > bd_r;
  end
  assign out_word = ow_r;

  `TVP_ASSERT_NEXT(a_start_accel, clk, rst_n, ctl.op == tvp_pkg::OP_START,
    ph_r == tvp_pkg::PH_ACCEL && cnt_r == 32'd0)
  `TVP_ASSERT_NEXT(a_tick_count, clk, rst_n, ctl.op == tvp_pkg::OP_TICK,
    cnt_r == $past(cnt_r) + 32'd1)
  `TVP_ASSERT_NEXT(a_finish_zero, clk, rst_n, ctl.op == tvp_pkg::OP_RAMP_SUB && rem_r <= 32'sd0,
    tv_r == 32'sd0 && ph_r == tvp_pkg::PH_FINISHED)
endmodule
`default_nettype wire

// ----- hdl/tvp_ctrl.sv -----
// Controller: sequences one input word through the datapath.
`default_nettype none
`include "trapezoid_velocity_profile_defines.svh"
module tvp_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  input  wire tvp_pkg::sts_t sts,
  output tvp_pkg::ctl_t      ctl
);
  tvp_pkg::st_t st_r, st_nxt;
  logic ov_r, ov_nxt;
  logic motion_ph;

  assign motion_ph = sts.phase inside {tvp_pkg::PH_ACCEL, tvp_pkg::PH_CRUISE,
                                       tvp_pkg::PH_BRAKE};

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      tvp_pkg::ST_IDLE:
        if (in_valid) st_nxt = tvp_pkg::ST_DECIDE;
      tvp_pkg::ST_DECIDE: begin
        if (sts.cmd == tvp_pkg::CMD_TICK && motion_ph) st_nxt = tvp_pkg::ST_SQ;
        else if (sts.cmd == tvp_pkg::CMD_TICK && sts.phase == tvp_pkg::PH_UBRAKE)
          st_nxt = tvp_pkg::ST_RAMP_MUL;
        else st_nxt = tvp_pkg::ST_OUT;
      end
      tvp_pkg::ST_SQ:      st_nxt = tvp_pkg::ST_DIV_BD;
      tvp_pkg::ST_DIV_BD:  st_nxt = tvp_pkg::ST_WAIT_BD;
      tvp_pkg::ST_WAIT_BD:
        if (!sts.div_busy) st_nxt = tvp_pkg::ST_CHECK;
      tvp_pkg::ST_CHECK:
        if (sts.phase == tvp_pkg::PH_BRAKE && sts.rem_gt_bd) st_nxt = tvp_pkg::ST_DIV_WA;
        else st_nxt = tvp_pkg::ST_STEP;
      tvp_pkg::ST_DIV_WA:  st_nxt = tvp_pkg::ST_WAIT_WA;
      tvp_pkg::ST_WAIT_WA:
        if (!sts.div_busy) st_nxt = tvp_pkg::ST_STEP;
      tvp_pkg::ST_STEP:
        if (sts.phase == tvp_pkg::PH_BRAKE) st_nxt = tvp_pkg::ST_RAMP_MUL;
        else st_nxt = tvp_pkg::ST_OUT;
      tvp_pkg::ST_RAMP_MUL: st_nxt = tvp_pkg::ST_RAMP_SUB;
      tvp_pkg::ST_RAMP_SUB: st_nxt = tvp_pkg::ST_OUT;
      tvp_pkg::ST_OUT:
        if (!ov_r || !out_stall) st_nxt = tvp_pkg::ST_IDLE;
      default: st_nxt = tvp_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl.op = tvp_pkg::OP_NOP;
    ov_nxt = ov_r && out_stall;
    in_stall = (st_r != tvp_pkg::ST_IDLE);
    case (st_r)
      tvp_pkg::ST_IDLE:
        if (in_valid) ctl.op = tvp_pkg::OP_LATCH_IN;
      tvp_pkg::ST_DECIDE:
        case (sts.cmd)
          tvp_pkg::CMD_START:  ctl.op = tvp_pkg::OP_START;
          tvp_pkg::CMD_URGENT: ctl.op = tvp_pkg::OP_URGENT;
          tvp_pkg::CMD_TICK:   ctl.op = tvp_pkg::OP_TICK;
          default:             ctl.op = tvp_pkg::OP_NOP;
        endcase
      tvp_pkg::ST_SQ:       ctl.op = tvp_pkg::OP_SQ;
      tvp_pkg::ST_DIV_BD:   ctl.op = tvp_pkg::OP_DIV_BD;
      tvp_pkg::ST_WAIT_BD:
        if (!sts.div_busy) ctl.op = tvp_pkg::OP_SAVE_BD;
      tvp_pkg::ST_DIV_WA:   ctl.op = tvp_pkg::OP_DIV_WA;
      tvp_pkg::ST_STEP:     ctl.op = tvp_pkg::OP_STEP;
      tvp_pkg::ST_RAMP_MUL: ctl.op = tvp_pkg::OP_RAMP_MUL;
      tvp_pkg::ST_RAMP_SUB: ctl.op = tvp_pkg::OP_RAMP_SUB;
      tvp_pkg::ST_OUT:
        if (!ov_r || !out_stall) begin
          ctl.op = tvp_pkg::OP_LOAD_OUT;
          ov_nxt = 1'b1;
        end
      default: ctl.op = tvp_pkg::OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= tvp_pkg::ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  assign out_valid = ov_r;

  `TVP_ASSERT_IMPL(a_accept_idle, clk, rst_n, in_valid && !in_stall,
    st_r == tvp_pkg::ST_IDLE)
  `TVP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `TVP_ASSERT_NEXT(a_load_valid, clk, rst_n, ctl.op == tvp_pkg::OP_LOAD_OUT, out_valid)
endmodule
`default_nettype wire

// ----- hdl/trapezoid_velocity_profile.sv -----
// Top level of the trapezoidal velocity setpoint generator.
// Usage:
//  - in_valid/in_stall carry one command word (tick, start, urgent stop)
//    with the remaining distance, signed Q16.16.
//  - out_valid/out_stall return one result word per command: velocity
//    setpoint, braking distance, phase and a finished flag.
//  - cfg_we/cfg_idx/cfg_data write max_velocity (0) and accel_per_sample (1)
//    while no word is in flight.
//  - Work per word: start, stop, unused code and ticks in idle, urgent
//    order or finished skip the arithmetic; a tick in urgent brake runs
//    the ramp multiply and subtract; an accelerating or cruising tick
//    squares, uses the 64-step divider for braking distance and steps; a
//    braking tick also ramps; a second divide may re-fit the accel.
//  - One word is worked on at a time; the next word may be accepted while
//    the previous result waits in the output register.
//  - Reset clears phase, counters, velocities and both registers.
//  - When the receiver stalls, the output word holds and a finished word
//    waits, which holds off further input.
`default_nettype none
module trapezoid_velocity_profile (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire tvp_pkg::in_word_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output tvp_pkg::out_word_t     out_data,
  input  wire logic              cfg_we,
  input  wire logic [0:0]        cfg_idx,
  input  wire logic [31:0]       cfg_data
);
  tvp_pkg::ctl_t ctl;
  tvp_pkg::sts_t sts;

  // sequence each word through the datapath
  tvp_ctrl u_ctrl (.clk(clk), .rst_n(rst_n), .in_valid(in_valid),
    .in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
    .sts(sts), .ctl(ctl));

  // hold profile state and arithmetic
  tvp_datapath u_dp (.clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
    .in_word(in_data), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_data(cfg_data), .out_word(out_data));
endmodule
`default_nettype wire
